### rtl/gec_pkg.sv
// Shared types and constants for the gradient edge contour unit.
// No dependencies.
package gec_pkg;

    localparam int PIXEL_PORT_W = 8;
    localparam int EDGE_W       = 8;
    localparam int ROW_W        = 12;
    localparam int FW_W         = 11;
    localparam int FH_W         = 12;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } gec_reg_t;

    // Result mask bits
    localparam int RES_ABOVE = 0;   // result for the row above, same column
    localparam int RES_LEFT  = 1;   // last row, previous column
    localparam int RES_SELF  = 2;   // last row, last column (end of frame)

    typedef struct packed {
        logic       last_col;
        logic [2:0] mask;
    } gec_ctl_t;

endpackage

### rtl/gec_line_mem.sv
// Line buffer: one write port, two registered read ports (read-first).
// No dependencies.
module gec_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

### rtl/gec_result_seq.sv
// Stage 1 item register and result sequencer with output register.
// Depends on gec_pkg; read data comes from gec_line_mem.
module gec_result_seq
    import gec_pkg::*;
#(
    parameter int PB = 8,
    parameter int CW = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [PB-1:0]     px,
    input  logic [PB-1:0]     lp,
    input  logic [CW-1:0]     col,
    input  logic [ROW_W-1:0]  row,
    input  gec_ctl_t          ctl,
    input  logic [PB-1:0]     up,
    input  logic [PB-1:0]     up_right,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [EDGE_W-1:0] edge_value,
    output logic [ROW_W-1:0]  out_row,
    output logic [CW-1:0]     out_col,
    output logic              last_of_run,
    output logic              end_of_frame
);

    function automatic logic [PB-1:0] absd(input logic [PB-1:0] a, input logic [PB-1:0] b);
        absd = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [EDGE_W-1:0] edge_of(input logic [PB-1:0] p,
                                                  input logic [PB-1:0] dn,
                                                  input logic [PB-1:0] rt);
        logic [PB:0] sum;
        sum = {1'b0, absd(p, dn)} + {1'b0, absd(p, rt)};
        edge_of = EDGE_W'(sum[PB:1]);
    endfunction

    logic              s1_valid_reg;
    logic [2:0]        rem_reg, rem_next;
    gec_ctl_t          ctl_reg;
    logic [PB-1:0]     px_reg, lp_reg, la_reg;
    logic [CW-1:0]     col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic              out_valid_reg;
    logic [EDGE_W-1:0] edge_reg;
    logic [ROW_W-1:0]  row_out_reg;
    logic [CW-1:0]     col_out_reg;
    logic              lor_reg, eof_reg;

    logic [2:0]        cur;
    logic              out_load, emit, single, retire;
    logic [PB-1:0]     rt0;
    logic [EDGE_W-1:0] e0, e1, e2, e_sel;
    logic [ROW_W-1:0]  r_sel;
    logic [CW-1:0]     c_sel;

    assign cur      = rem_reg & (~rem_reg + 3'd1);   // lowest pending result
    assign single   = (rem_reg == cur);
    assign out_load = !out_valid_reg || !out_stall;
    assign emit     = s1_valid_reg && (rem_reg != 3'd0) && out_load;
    assign retire   = s1_valid_reg && ((rem_reg == 3'd0) || (emit && single));
    assign free     = !s1_valid_reg || retire;
    assign rem_next = rem_reg & ~cur;

    assign rt0 = ctl_reg.last_col ? la_reg : up_right;
    assign e0  = edge_of(up, px_reg, rt0);
    assign e1  = edge_of(lp_reg, la_reg, px_reg);
    assign e2  = edge_of(px_reg, up, lp_reg);

    always_comb
    begin
        e_sel = e0;
        r_sel = row_reg - ROW_W'(1);
        c_sel = col_reg;
        if (cur[RES_LEFT])
        begin
            e_sel = e1;
            r_sel = row_reg;
            c_sel = col_reg - CW'(1);
        end
        else if (cur[RES_SELF])
        begin
            e_sel = e2;
            r_sel = row_reg;
            c_sel = col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rem_reg       <= 3'd0;
            la_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
                rem_reg      <= ctl.mask;
            end
            else if (retire)
            begin
                s1_valid_reg <= 1'b0;
                rem_reg      <= 3'd0;
            end
            else if (emit)
            begin
                rem_reg <= rem_next;
            end
            // previous-row value left of the next column
            if (retire)
            begin
                la_reg <= up;
            end
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg  <= px;
            lp_reg  <= lp;
            col_reg <= col;
            row_reg <= row;
            ctl_reg <= ctl;
        end
        if (emit)
        begin
            edge_reg    <= e_sel;
            row_out_reg <= r_sel;
            col_out_reg <= c_sel;
            lor_reg     <= single;
            eof_reg     <= cur[RES_SELF];
        end
    end

    assign out_valid    = out_valid_reg;
    assign edge_value   = edge_reg;
    assign out_row      = row_out_reg;
    assign out_col      = col_out_reg;
    assign last_of_run  = lor_reg;
    assign end_of_frame = eof_reg;

endmodule

### rtl/gradient_edge_contour_unit.sv
// Top level of the gradient edge contour unit: config port, raster counters.
// Depends on gec_pkg, gec_line_mem, gec_result_seq.
//
// Usage:
//  - Pixels enter in raster order on in_valid/pixel; an item is taken at a
//    clock edge with in_valid high and in_stall low.
//  - Each pixel of row r > 0 yields the edge result of (r-1, c). In the last
//    row a pixel past column 0 also yields (r, c-1), and the last pixel
//    adds (r, c) with end_of_frame set. last_of_run marks the final result
//    of each pixel. Pixels of row 0 produce no result.
//  - A taken pixel is held in the result stage beside its line buffer read;
//    its results then pass one by one to the output register.
//  - Throughput: one pixel per cycle while the output is not stalled; in the
//    last row one result per cycle (one at column 0, two per pixel after
//    that, three on the final one), set by the single output register.
//  - out_stall freezes the output register; the result stage then fills and
//    in_stall rises in the same cycle.
//  - frame_width (addr 0) and frame_height (addr 4) are to be written over
//    APB only while the stream is idle; the block does not enforce this.
//    Width is clamped to 2..MAX_WIDTH, height to at least 2.
//  - Reset clears counters and valid flags and sets frame size to 640 x 480.
//    The line buffer is not cleared: row 0 fills it before its data is used.
module gradient_edge_contour_unit
    import gec_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // pixel in
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PIXEL_PORT_W-1:0]       pixel,
    // results out
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [EDGE_W-1:0]             edge_value,
    output logic [ROW_W-1:0]              out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
    output logic                          last_of_run,
    output logic                          end_of_frame
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    logic [FW_W-1:0]       fw_reg;
    logic [FH_W-1:0]       fh_reg;
    logic [CW-1:0]         col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [PIXEL_BITS-1:0] lp_reg;

    logic [PIXEL_BITS-1:0] px;
    logic [CMPW-1:0]       w_eff;
    logic [FH_W-1:0]       h_eff;
    logic                  last_col, last_row, accept, free, cfg_wr;
    gec_ctl_t              ctl;
    logic [PIXEL_BITS-1:0] up, up_right;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (gec_reg_t'(paddr[2]))
            REG_FRAME_WIDTH:  prdata = 32'(fw_reg);
            REG_FRAME_HEIGHT: prdata = 32'(fh_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_W'(640);
            fh_reg <= FH_W'(480);
        end
        else if (cfg_wr)
        begin
            unique case (gec_reg_t'(paddr[2]))
                REG_FRAME_WIDTH:  fw_reg <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= pwdata[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- raster position ----------------
    always_comb
    begin
        w_eff = CMPW'(fw_reg);
        if (w_eff < CMPW'(2))
        begin
            w_eff = CMPW'(2);
        end
        else if (w_eff > CMPW'(MAX_WIDTH))
        begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        h_eff = (fh_reg < FH_W'(2)) ? FH_W'(2) : fh_reg;
    end

    // a count at or past the last index counts as last (mid-frame resize)
    assign last_col = (CMPW'(col_reg) >= (w_eff - CMPW'(1)));
    assign last_row = (row_reg >= (h_eff - FH_W'(1)));

    assign px       = PIXEL_BITS'(pixel);
    assign in_stall = !free;
    assign accept   = in_valid && free;

    always_comb
    begin
        ctl.last_col           = last_col;
        ctl.mask[RES_ABOVE]    = (row_reg != '0);
        ctl.mask[RES_LEFT]     = (row_reg != '0) && last_row && (col_reg != '0);
        ctl.mask[RES_SELF]     = (row_reg != '0) && last_row && last_col;

        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            lp_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            lp_reg  <= px;
        end
    end

    // ---------------- line buffer ----------------
    // Reads column c and c+1 of the previous row while c is overwritten.
    gec_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (PIXEL_BITS)
    ) u_line_mem (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr_a (col_reg),
        .rd_addr_b (col_reg + CW'(1)),
        .rd_data_a (up),
        .rd_data_b (up_right),
        .wr_en     (accept),
        .wr_addr   (col_reg),
        .wr_data   (px)
    );

    // ---------------- result stage ----------------
    gec_result_seq #(
        .PB (PIXEL_BITS),
        .CW (CW)
    ) u_result_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .px           (px),
        .lp           (lp_reg),
        .col          (col_reg),
        .row          (row_reg),
        .ctl          (ctl),
        .up           (up),
        .up_right     (up_right),
        .free         (free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_value   (edge_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

endmodule

### rtl/gec_checker.sv
// Port-level checks for gradient_edge_contour_unit, with bind.
// Depends on the top level's ports and its MAX_WIDTH parameter.
module gec_checker #(
    parameter int CW = 10
) (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_stall,
    input logic [7:0]    edge_value,
    input logic [11:0]   out_row,
    input logic [CW-1:0] out_col,
    input logic          last_of_run,
    input logic          end_of_frame
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(edge_value) && $stable(out_row)
            && $stable(out_col) && $stable(last_of_run) && $stable(end_of_frame))
        else $error("stalled result changed");

    // the frame's final result ends its pixel's run
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_run)
        else $error("end_of_frame without last_of_run");

    // a run that is not finished continues in the next cycle
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("run broken");

endmodule

bind gradient_edge_contour_unit gec_checker #(
    .CW ($clog2(MAX_WIDTH))
) u_gec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .edge_value   (edge_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
);
